// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the priority queue checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic signed [31:0] EMPTY_HEAD = 32'sh7FFF_FFFF;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] priority_req;
    logic signed [31:0] payload;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] head_priority;
    logic signed [31:0] head_payload;
    logic               is_empty;
    logic [4:0]         occupancy;
  } spq_resp_t;

  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] data;
  } spq_entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic       insert;
    logic       remove;
    spq_entry_t entry;
  } spq_op_t;

endpackage

// File: design/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue held as a sorted chain of cells, head in cell 0.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | spq_req_t  (mode, priority, data)
//  resp    | out       | resp_valid/resp_stall | spq_resp_t (status, head, count)
//
// Every cell compares against the request in parallel and the whole chain
// shifts together when a request is taken; its response sits in an
// output register on the next cycle. A new request is taken each cycle unless
// that register holds an unclaimed response under stall.
// Reset empties the queue by clearing the count; cell contents are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  spq_req_t  req,
  output logic      resp_valid,
  input  logic      resp_stall,
  output spq_resp_t resp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic          accept;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          full;
  logic          empty;
  spq_op_t       op;
  logic [1:0]    status_next;

  logic       ge         [CAPACITY];
  logic       occupied   [CAPACITY];
  spq_entry_t entry      [CAPACITY];
  spq_entry_t entry_next [CAPACITY];

  assign req_stall = resp_valid && resp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  always_comb begin
    op.entry.prio = req.priority_req;
    op.entry.data = req.payload;
    op.insert     = accept && (req.mode == MODE_INSERT) && !full;
    op.remove     = accept && (req.mode == MODE_REMOVE) && !empty;
    count_next    = count;
    if (op.insert) begin
      count_next = count + CW'(1);
    end else if (op.remove) begin
      count_next = count - CW'(1);
    end
    status_next = STATUS_OK;
    if (req.mode == MODE_INSERT && full) begin
      status_next = STATUS_FULL;
    end else if (req.mode == MODE_REMOVE && empty) begin
      status_next = STATUS_EMPTY;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = (count > CW'(i));
    spq_cell u_cell (
      .clk         (clk),
      .op          (op),
      .occupied    (occupied[i]),
      .left_ge     ((i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i - 1]),
      .left_entry  ((i == 0) ? op.entry : entry[(i == 0) ? 0 : i - 1]),
      .right_entry (entry[(i == CAPACITY - 1) ? i : i + 1]),
      .ge          (ge[i]),
      .entry       (entry[i]),
      .entry_next  (entry_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      resp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        resp_valid <= 1'b1;
      end else if (!resp_stall) begin
        resp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp.status    <= status_next;
      resp.occupancy <= 5'(count_next);
      if (count_next == '0) begin
        resp.head_priority <= EMPTY_HEAD;
        resp.head_payload  <= EMPTY_HEAD;
        resp.is_empty      <= 1'b1;
      end else begin
        resp.head_priority <= entry_next[0].prio;
        resp.head_payload  <= entry_next[0].data;
        resp.is_empty      <= 1'b0;
      end
    end
  end

endmodule

// File: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_op_t    op,
  input  logic       occupied,
  input  logic       left_ge,
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output logic       ge,
  output spq_entry_t entry,
  output spq_entry_t entry_next
);

  // Stored entry ranks ahead of (or ties with) the incoming one.
  assign ge = occupied && (entry.prio >= op.entry.prio);

  always_comb begin
    entry_next = entry;
    if (op.insert) begin
      if (!ge) begin
        entry_next = left_ge ? op.entry : left_entry;
      end
    end else if (op.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker
  import spq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input spq_req_t  req,
  input logic      resp_valid,
  input logic      resp_stall,
  input spq_resp_t resp
);

  logic req_seen;
  assign req_seen = req_valid && (req.mode == MODE_INSERT || req.mode == MODE_REMOVE);

  // An accepted request yields a response on the next cycle.
  `ASSERT_NEXT(a_req_to_resp, clk, rst, req_seen && !req_stall, resp_valid)
  // A stalled response holds.
  `ASSERT_NEXT(a_resp_hold, clk, rst, resp_valid && resp_stall,
               resp_valid && $stable(resp))
  // An empty queue reports the empty head and no entries.
  `ASSERT_IMPLY(a_empty_head, clk, rst, resp_valid && resp.is_empty,
                resp.head_priority == EMPTY_HEAD && resp.head_payload == EMPTY_HEAD &&
                resp.occupancy == 5'd0)
  // A rejected insert means the queue holds entries.
  `ASSERT_IMPLY(a_full_nonempty, clk, rst, resp_valid && resp.status == STATUS_FULL,
                !resp.is_empty)

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .req        (req),
  .resp_valid (resp_valid),
  .resp_stall (resp_stall),
  .resp       (resp)
);

// File: bench/tb_sorted_priority_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit
// Self-checking bench for the sorted priority queue. Inserts and head removals
// go in through the request channel. A scoreboard keeps its own sorted copy of
// the queue and works out the status, head and count that each response must
// carry. Both channels idle at random, and the queue is driven to full and
// back to empty many times over.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_REQUESTS = 1200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_TAIL = 1000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  spq_req_t  req;
  logic      resp_valid;
  logic      resp_stall;
  spq_resp_t resp;

  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  bit long_hold_request = 1'b0;

  // Sorted shadow of the queue plus the responses it still owes.
  class queue_scoreboard;
    spq_entry_t slots [QUEUE_DEPTH];
    int         count;
    spq_resp_t  pending [$];
    int         errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void note_request(spq_req_t r);
      spq_resp_t e;
      int pos;
      e = '0;
      e.status = STATUS_OK;
      if (r.mode == MODE_INSERT) begin
        if (count >= QUEUE_DEPTH) begin
          e.status = STATUS_FULL;
        end else begin
          // go behind every entry of greater or equal priority
          pos = 0;
          while (pos < count && $signed(slots[pos].prio) >= $signed(r.priority_req))
            pos++;
          for (int k = count; k > pos; k--)
            slots[k] = slots[k-1];
          slots[pos].prio = r.priority_req;
          slots[pos].data = r.payload;
          count++;
        end
      end else begin
        if (count == 0) begin
          e.status = STATUS_EMPTY;
        end else begin
          for (int k = 1; k < count; k++)
            slots[k-1] = slots[k];
          count--;
        end
      end
      if (count == 0) begin
        e.head_priority = EMPTY_HEAD;
        e.head_payload = EMPTY_HEAD;
        e.is_empty = 1'b1;
      end else begin
        e.head_priority = slots[0].prio;
        e.head_payload = slots[0].data;
        e.is_empty = 1'b0;
      end
      e.occupancy = 5'(count);
      pending.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      end
    endfunction

    function void check_response(spq_resp_t r);
      spq_resp_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: response with no request outstanding, expected none, actual %0h",
                 $time, r);
      end else begin
        e = pending.pop_front();
        compare_field("status", 32'(e.status), 32'(r.status));
        compare_field("head_priority", e.head_priority, r.head_priority);
        compare_field("head_payload", e.head_payload, r.head_payload);
        compare_field("is_empty", 32'(e.is_empty), 32'(r.is_empty));
        compare_field("occupancy", 32'(e.occupancy), 32'(r.occupancy));
      end
    endfunction
  endclass

  queue_scoreboard sb = new();

  sorted_priority_queue_unit #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .resp_valid(resp_valid),
    .resp_stall(resp_stall),
    .resp(resp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check accepted responses and drive stall for the next cycle.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    resp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst !== 1'b1 && resp_valid === 1'b1 && resp_stall === 1'b0)
        sb.check_response(resp);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        resp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        resp_stall <= 1'b1;
      end else begin
        resp_stall <= 1'b0;
        if (rx_idling && $urandom_range(0, 3) == 0)
          stall_left = $urandom_range(1, 8);
      end
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_priority_queue_unit regression: fail");
    $finish;
  end

  // Offer one request and hold it until taken; maybe idle afterwards.
  task automatic issue(spq_req_t r);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_request(r);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic spq_req_t make_request(logic mode, logic signed [31:0] prio,
                                            logic signed [31:0] data);
    spq_req_t r;
    r.mode = mode;
    r.priority_req = prio;
    r.payload = data;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_priority();
    logic signed [31:0] p;
    case ($urandom_range(0, 4))
      0: p = $urandom();
      1: p = 32'($urandom_range(0, 7)) - 32'sd4;   // dense ties
      2: begin
        case ($urandom_range(0, 3))
          0: p = 32'sh7FFF_FFFF;
          1: p = 32'sh8000_0000;
          2: p = 32'sd0;
          default: p = -32'sd1;
        endcase
      end
      default: p = 32'($urandom_range(0, 200)) - 32'sd100;
    endcase
    return p;
  endfunction

  task automatic run_directed();
    logic signed [31:0] prios [16] = '{
      32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sh7FFF_FFFF,
      32'sd5, 32'sh8000_0000, 32'sd5, 32'sd5, -32'sd100, 32'sd1000,
      32'sh7FFF_FFFE, 32'sh8000_0001, 32'sd0, 32'sd5
    };
    logic signed [31:0] datas [16] = '{
      32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sh8000_0000, 32'sh7FFF_FFFF,
      -32'sd1, 32'sd0, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd11, 32'sd12,
      32'sd13, 32'sd14, 32'sd15, 32'sd16
    };
    // remove from an empty queue
    issue(make_request(MODE_REMOVE, 32'sh7FFF_FFFF, 32'sh8000_0000));
    for (int i = 0; i < 16; i++)
      issue(make_request(MODE_INSERT, prios[i], datas[i]));
    // insert into a full queue
    issue(make_request(MODE_INSERT, 32'sh7FFF_FFFF, 32'sh1234_5678));
    for (int i = 0; i < 7; i++)
      issue(make_request(MODE_REMOVE, 32'sd0, 32'sd0));
  endtask

  task automatic run_random();
    int insert_mix [5] = '{85, 50, 15, 95, 5};
    int insert_pct;
    spq_req_t r;
    insert_pct = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0)
        insert_pct = insert_mix[$urandom_range(0, 4)];
      // long receiver hold while requests keep coming, so the input backs up
      if (n == 300) begin
        tx_idling = 1'b0;
        long_hold_request = 1'b1;
      end
      if (n == 360)
        tx_idling = 1'b1;
      // drain completely before going on
      if (n == 600) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
      end
      if (n == QUIET_TAIL) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end
      r.mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
      r.priority_req = pick_priority();
      r.payload = $urandom();
      issue(r);
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("sorted_priority_queue_unit regression: pass");
    else
      $display("sorted_priority_queue_unit regression: fail");
    $finish;
  end

endmodule
